FILE: design/rpq_pkg.sv
// ----------------------------------------------------------------------------
// rpq_pkg
// Shared widths, codes and types of the range-assign / point-query tree.
// ----------------------------------------------------------------------------
package rpq_pkg;

   localparam int MAX_POSITIONS = 1024;
   localparam int TREE_NODES    = 4 * MAX_POSITIONS;
   localparam int NODE_W        = $clog2(TREE_NODES);
   localparam int POS_W         = 10;
   localparam int VAL_W         = 16;
   localparam int LEN_W         = 11;
   localparam int TAG_W         = VAL_W + 1;
   localparam int STACK_DEPTH   = 16;
   localparam int STACK_IDX_W   = $clog2(STACK_DEPTH);
   localparam int SP_W          = STACK_IDX_W + 1;

   localparam logic OP_ASSIGN = 1'b0;
   localparam logic OP_QUERY  = 1'b1;

   // node word: top bit marks a pending tag, the rest is its value
   localparam logic [TAG_W-1:0] TAG_RESET = {1'b1, {VAL_W{1'b0}}};

   typedef struct packed {
      logic [NODE_W-1:0] node;
      logic [POS_W-1:0]  nl;
      logic [POS_W-1:0]  nr;
   } frame_type;

   typedef struct packed {
      logic             valid;
      logic [VAL_W-1:0] value;
   } result_type;

endpackage

FILE: design/rpq_req_if.sv
// ----------------------------------------------------------------------------
// rpq_req_if
// Request channel: one assign or query per beat.
// ----------------------------------------------------------------------------
interface rpq_req_if;
   logic                      valid;
   logic                      ready;
   logic                      operation;
   logic [rpq_pkg::POS_W-1:0] range_low;
   logic [rpq_pkg::POS_W-1:0] range_high;
   logic [rpq_pkg::VAL_W-1:0] new_value;
   logic [rpq_pkg::POS_W-1:0] position;

   modport source (output valid, operation, range_low, range_high, new_value, position,
                   input ready);
   modport sink   (input valid, operation, range_low, range_high, new_value, position,
                   output ready);
endinterface

FILE: design/rpq_rsp_if.sv
// ----------------------------------------------------------------------------
// rpq_rsp_if
// Response channel: one read value per query beat.
// ----------------------------------------------------------------------------
interface rpq_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [rpq_pkg::VAL_W-1:0] read_value;

   modport source (output valid, read_value, input ready);
   modport sink   (input valid, read_value, output ready);
endinterface

FILE: design/range_assign_point_query_tree_core.sv
// ----------------------------------------------------------------------------
// range_assign_point_query_tree_core
// Segment tree of lazy assignment tags with range assign and point query.
// ----------------------------------------------------------------------------
// req_chan carries one item per beat: operation 0 assigns new_value to the
// positions range_low..range_high (high clipped to length-1, an empty range
// is dropped), operation 1 reads the value at position (clipped likewise).
// rsp_chan returns one read_value beat per query; assigns return nothing.
// csr_wr_en/csr_wr_data set the number of positions (0 acts as 1, above
// 1024 as 1024) and clear the tree; write only while the block is idle.
// One item is in flight at a time. The tag RAM is single-read, single-write
// with a registered read, so every visited node passes a read state and an
// evaluate state: a query is accepted, walks down to the first tagged node
// (at most 11 levels for 1024 positions) and hands over its value. An assign
// is accepted, reads and evaluates each visited node, writes both children
// in turn per push-down and passes a descent state per descent and a pop
// state per finished branch; it visits up to about four nodes per level.
// After reset and after every csr write a clearing pass over all 4096 nodes
// refills the tag RAM; req_chan.ready stays low meanwhile. The result sits
// in an output register; a stalled receiver holds the walker in its result
// state, and new requests wait until that result has left the engine.
// ----------------------------------------------------------------------------
module range_assign_point_query_tree_core (
   input  logic                           clock,
   input  logic                           reset,
   rpq_req_if.sink                        req_chan,
   rpq_rsp_if.source                      rsp_chan,
   input  logic                           csr_wr_en,
   input  logic [rpq_pkg::LEN_W-1:0]      csr_wr_data
);

   logic [rpq_pkg::LEN_W-1:0]  length_ff, length_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [rpq_pkg::VAL_W-1:0]  rsp_data_ff, rsp_data_in;
   rpq_pkg::result_type        result;
   logic                       result_take;
   logic                       ram_wr_en;
   logic [rpq_pkg::NODE_W-1:0] ram_wr_addr;
   logic [rpq_pkg::TAG_W-1:0]  ram_wr_data;
   logic                       ram_rd_en;
   logic [rpq_pkg::NODE_W-1:0] ram_rd_addr;
   logic [rpq_pkg::TAG_W-1:0]  ram_rd_data;

   always_comb begin
      length_in = length_ff;
      if (csr_wr_en) begin
         if (csr_wr_data == '0) begin
            length_in = rpq_pkg::LEN_W'(1);
         end else if (csr_wr_data > rpq_pkg::LEN_W'(rpq_pkg::MAX_POSITIONS)) begin
            length_in = rpq_pkg::LEN_W'(rpq_pkg::MAX_POSITIONS);
         end else begin
            length_in = csr_wr_data;
         end
      end
   end

   // output register: free when empty or being drained this cycle
   assign result_take  = !rsp_valid_ff || rsp_chan.ready;
   assign rsp_valid_in = result.valid || (rsp_valid_ff && !rsp_chan.ready);
   assign rsp_data_in  = (result.valid && result_take) ? result.value : rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff    <= rpq_pkg::LEN_W'(rpq_pkg::MAX_POSITIONS);
         rsp_valid_ff <= 1'b0;
      end else begin
         length_ff    <= length_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.read_value = rsp_data_ff;

   rpq_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .req         (req_chan),
      .clear_start (csr_wr_en),
      .length      (length_ff),
      .result      (result),
      .result_take (result_take),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data)
   );

   rpq_tag_ram #(
      .DEPTH (rpq_pkg::TREE_NODES),
      .WIDTH (rpq_pkg::TAG_W)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule

FILE: design/rpq_tag_ram.sv
// ----------------------------------------------------------------------------
// rpq_tag_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module rpq_tag_ram #(
   parameter int DEPTH  = 4096,
   parameter int WIDTH  = 17,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/rpq_engine.sv
// ----------------------------------------------------------------------------
// rpq_engine
// Tree walker: clears the tag RAM, walks it for queries and runs the
// depth-first assign with push-down, keeping pending right subtrees on a stack.
// ----------------------------------------------------------------------------
module rpq_engine (
   input  logic                               clock,
   input  logic                               reset,
   rpq_req_if.sink                            req,
   input  logic                               clear_start,
   input  logic [rpq_pkg::LEN_W-1:0]          length,
   output rpq_pkg::result_type                result,
   input  logic                               result_take,
   output logic                               ram_wr_en,
   output logic [rpq_pkg::NODE_W-1:0]         ram_wr_addr,
   output logic [rpq_pkg::TAG_W-1:0]          ram_wr_data,
   output logic                               ram_rd_en,
   output logic [rpq_pkg::NODE_W-1:0]         ram_rd_addr,
   input  logic [rpq_pkg::TAG_W-1:0]          ram_rd_data
);

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_RD    = 4'd2;
   localparam logic [3:0] S_EVAL  = 4'd3;
   localparam logic [3:0] S_PUSHL = 4'd4;
   localparam logic [3:0] S_PUSHR = 4'd5;
   localparam logic [3:0] S_DESC  = 4'd6;
   localparam logic [3:0] S_POP   = 4'd7;
   localparam logic [3:0] S_RESP  = 4'd8;

   localparam int POS_W  = rpq_pkg::POS_W;
   localparam int NODE_W = rpq_pkg::NODE_W;
   localparam int VAL_W  = rpq_pkg::VAL_W;
   localparam int TAG_W  = rpq_pkg::TAG_W;
   localparam int SP_W   = rpq_pkg::SP_W;
   localparam int SIDX_W = rpq_pkg::STACK_IDX_W;

   logic [3:0]               state_ff, state_in;
   logic                     op_ff, op_in;
   logic [POS_W-1:0]         lo_ff, lo_in;
   logic [POS_W-1:0]         hi_ff, hi_in;
   logic [VAL_W-1:0]         val_ff, val_in;
   logic [POS_W-1:0]         pos_ff, pos_in;
   rpq_pkg::frame_type       cur_ff, cur_in;
   logic [TAG_W-1:0]         tag_ff, tag_in;
   logic [VAL_W-1:0]         res_ff, res_in;
   logic [NODE_W-1:0]        clr_ff, clr_in;
   logic [SP_W-1:0]          sp_ff, sp_in;
   rpq_pkg::frame_type       stk_ff [rpq_pkg::STACK_DEPTH];

   logic                     push_en;
   rpq_pkg::frame_type       push_frame;
   logic [SP_W-1:0]          sp_dec;
   logic [POS_W-1:0]         last;
   logic [POS_W-1:0]         hi_clip;
   logic [POS_W-1:0]         pos_clip;
   logic [POS_W:0]           mid_sum;
   logic [POS_W-1:0]         mid;
   logic [POS_W:0]           mid_inc;
   logic [NODE_W-1:0]        left_node;
   logic [NODE_W-1:0]        right_node;
   logic                     covered;
   logic                     is_leaf;
   rpq_pkg::frame_type       root;

   assign last       = POS_W'(length - rpq_pkg::LEN_W'(1));
   assign hi_clip    = (req.range_high > last) ? last : req.range_high;
   assign pos_clip   = (req.position > last) ? last : req.position;
   assign mid_sum    = {1'b0, cur_ff.nl} + {1'b0, cur_ff.nr};
   assign mid        = mid_sum[POS_W:1];
   assign mid_inc    = {1'b0, mid} + (POS_W+1)'(1);
   assign left_node  = {cur_ff.node[NODE_W-2:0], 1'b0};
   assign right_node = {cur_ff.node[NODE_W-2:0], 1'b1};
   assign covered    = (cur_ff.nl >= lo_ff) && (cur_ff.nr <= hi_ff);
   assign is_leaf    = (cur_ff.nl >= cur_ff.nr);
   assign sp_dec     = sp_ff - SP_W'(1);
   assign root       = '{node: NODE_W'(1), nl: '0, nr: last};

   assign req.ready    = (state_ff == S_IDLE);
   assign result.valid = (state_ff == S_RESP);
   assign result.value = res_ff;

   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      val_in      = val_ff;
      pos_in      = pos_ff;
      cur_in      = cur_ff;
      tag_in      = tag_ff;
      res_in      = res_ff;
      clr_in      = clr_ff;
      sp_in       = sp_ff;
      push_en     = 1'b0;
      push_frame  = '{node: right_node, nl: mid_inc[POS_W-1:0], nr: cur_ff.nr};
      ram_wr_en   = 1'b0;
      ram_wr_addr = cur_ff.node;
      ram_wr_data = '0;
      ram_rd_en   = 1'b0;
      ram_rd_addr = cur_ff.node;

      unique case (state_ff)
         S_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_ff;
            ram_wr_data = rpq_pkg::TAG_RESET;
            clr_in      = clr_ff + NODE_W'(1);
            if (clr_ff == NODE_W'(rpq_pkg::TREE_NODES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req.valid) begin
               op_in  = req.operation;
               lo_in  = req.range_low;
               hi_in  = hi_clip;
               val_in = req.new_value;
               pos_in = pos_clip;
               cur_in = root;
               sp_in  = '0;
               // drop an empty assign at once
               if (req.operation == rpq_pkg::OP_QUERY || req.range_low <= hi_clip) begin
                  state_in = S_RD;
               end
            end
         end
         S_RD: begin
            ram_rd_en = 1'b1;
            state_in  = S_EVAL;
         end
         S_EVAL: begin
            if (op_ff == rpq_pkg::OP_QUERY) begin
               if (ram_rd_data[TAG_W-1]) begin
                  res_in   = ram_rd_data[VAL_W-1:0];
                  state_in = S_RESP;
               end else if (is_leaf) begin
                  res_in   = '0;
                  state_in = S_RESP;
               end else begin
                  if (pos_ff <= mid) begin
                     cur_in = '{node: left_node, nl: cur_ff.nl, nr: mid};
                  end else begin
                     cur_in = '{node: right_node, nl: mid_inc[POS_W-1:0], nr: cur_ff.nr};
                  end
                  state_in = S_RD;
               end
            end else if (covered) begin
               ram_wr_en   = 1'b1;
               ram_wr_data = {1'b1, val_ff};
               state_in    = S_POP;
            end else if (is_leaf) begin
               state_in = S_POP;
            end else if (ram_rd_data[TAG_W-1]) begin
               // clear the node, hand its tag to both children
               ram_wr_en   = 1'b1;
               ram_wr_data = '0;
               tag_in      = ram_rd_data;
               state_in    = S_PUSHL;
            end else begin
               state_in = S_DESC;
            end
         end
         S_PUSHL: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = left_node;
            ram_wr_data = tag_ff;
            state_in    = S_PUSHR;
         end
         S_PUSHR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = right_node;
            ram_wr_data = tag_ff;
            state_in    = S_DESC;
         end
         S_DESC: begin
            if (mid >= lo_ff) begin
               if (mid_inc <= {1'b0, hi_ff}) begin
                  push_en = 1'b1;
                  sp_in   = sp_ff + SP_W'(1);
               end
               cur_in = '{node: left_node, nl: cur_ff.nl, nr: mid};
            end else begin
               cur_in = '{node: right_node, nl: mid_inc[POS_W-1:0], nr: cur_ff.nr};
            end
            state_in = S_RD;
         end
         S_POP: begin
            if (sp_ff == '0) begin
               state_in = S_IDLE;
            end else begin
               cur_in   = stk_ff[sp_dec[SIDX_W-1:0]];
               sp_in    = sp_dec;
               state_in = S_RD;
            end
         end
         S_RESP: begin
            if (result_take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (clear_start) begin
         clr_in   = '0;
         state_in = S_CLEAR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
         sp_ff    <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         sp_ff    <= sp_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      val_ff <= val_in;
      pos_ff <= pos_in;
      cur_ff <= cur_in;
      tag_ff <= tag_in;
      res_ff <= res_in;
      if (push_en) begin
         stk_ff[sp_ff[SIDX_W-1:0]] <= push_frame;
      end
   end

`ifndef ASSERT_OFF
   a_stack_bound: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= SP_W'(rpq_pkg::STACK_DEPTH))
      else $error("walk stack overflow");

   a_read_then_eval: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RD && !clear_start) |=> state_ff == S_EVAL)
      else $error("read data not evaluated in the following cycle");

   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLEAR |-> !req.ready)
      else $error("request accepted during clear pass");

   a_push_from_partial: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_PUSHL |-> $past(state_ff) == S_EVAL && op_ff == rpq_pkg::OP_ASSIGN)
      else $error("push-down outside an assign");
`endif

endmodule
